### src/lsfa_pkg.sv
`default_nettype none
package lsfa_pkg;

  // Field widths of the channels and registers
  localparam int SAMPLE_W     = 12;
  localparam int PIX_OUT_W    = 8;
  localparam int AVG_OUT_W    = 12;
  localparam int TRANS_W      = 19;
  localparam int NUM_FRAMES_W = 9;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 9;

  // Storage and arithmetic
  localparam int ACC_W   = 20;
  localparam int BASE_W  = 12;
  localparam int PCT_W   = 7;
  localparam int PERCENT = 100;
  localparam int MIN_RESET = 4095;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_FRAMES = 1'b0,
    REG_CAPTURE    = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

### src/lsfa_in_if.sv
`default_nettype none
interface lsfa_in_if;
  import lsfa_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                restart;

  modport source (output valid, sample, restart, input ready);
  modport sink (input valid, sample, restart, output ready);
endinterface
`default_nettype wire

### src/lsfa_out_if.sv
`default_nettype none
interface lsfa_out_if;
  import lsfa_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [PIX_OUT_W-1:0] pixel_index;
  logic [AVG_OUT_W-1:0] average;
  logic [TRANS_W-1:0]   transmission;
  logic                 no_baseline;
  logic [AVG_OUT_W-1:0] running_min;
  logic [AVG_OUT_W-1:0] running_max;
  logic                 last;

  modport source (output valid, pixel_index, average, transmission, no_baseline,
                  running_min, running_max, last, input ready);
  modport sink (input valid, pixel_index, average, transmission, no_baseline,
                running_min, running_max, last, output ready);
endinterface
`default_nettype wire

### src/lsfa_ram.sv
`default_nettype none
module lsfa_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### src/lsfa_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module lsfa_div #(
  parameter int N = 20,
  parameter int M = 13
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [N-1:0]       dividend,
  input  wire logic [M-1:0]       divisor,
  output lsfa_pkg::div_stat_t     stat,
  output logic      [N-1:0]       quotient
);
  import lsfa_pkg::*;

  localparam int CNT_W = $clog2(N + 1);

  logic [N-1:0]     quo_r;
  logic [M-1:0]     rem_r;
  logic [M-1:0]     dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [M:0]   trial;
  logic [M:0]   diff;
  logic         ge;
  logic [M-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[N-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? diff[M-1:0] : trial[M-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
        cnt_r  <= CNT_W'(N);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        quo_r <= {quo_r[N-2:0], ge};
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_r)
    else $error("divider started while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("divider done while still busy");
  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
                                 busy_r |-> cnt_r != '0)
    else $error("divider busy with empty count");

endmodule
`default_nettype wire

### src/linear_sensor_frame_averager.sv
// Non-final frames: each sample is accepted, then its accumulator entry is updated,
// before the next sample is taken. Final frame: each sample also waits on the shared
// one-bit-per-cycle divider that first forms the average, then the transmission; a
// zero baseline skips the second division.
// Reset is synchronous; afterwards every baseline entry is swept to zero, during
// which no sample is taken (config writes still land).
`default_nettype none
module linear_sensor_frame_averager #(
  parameter int PIXELS      = 256,
  parameter int MAX_FRAMES  = 256,
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [lsfa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lsfa_pkg::CFG_DATA_W-1:0]  cfg_data,
  lsfa_in_if.sink                               in_ch,
  lsfa_out_if.source                            out_ch
);
  import lsfa_pkg::*;

  localparam int PIX_W   = $clog2(PIXELS);
  localparam int NF_W    = $clog2(MAX_FRAMES + 1);
  localparam int CMP_W   = (NF_W > NUM_FRAMES_W) ? NF_W : NUM_FRAMES_W;
  localparam int MM_W    = (SAMPLE_BITS > AVG_OUT_W) ? SAMPLE_BITS : AVG_OUT_W;
  localparam int PROD_W  = SAMPLE_BITS + PCT_W;
  localparam int DIV_N   = (PROD_W > ACC_W) ? PROD_W : ACC_W;
  localparam int DIV_M   = (NF_W > BASE_W) ? NF_W : BASE_W;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
  localparam logic [PIX_W-1:0]       PIX_LAST   = PIX_W'(PIXELS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ACC,
    S_AVG,
    S_TRN,
    S_OUT
  } state_t;

  state_t state_r;

  // configuration
  logic [NUM_FRAMES_W-1:0] num_frames_r;
  logic                    capture_r;

  // sequencing counters
  logic [PIX_W-1:0] pix_r;
  logic [NF_W-1:0]  frame_r;
  logic [PIX_W-1:0] clr_r;

  // item in flight
  logic [SAMPLE_BITS-1:0] sample_r;
  logic [PIX_W-1:0]       pix_item_r;
  logic                   first_frame_r;
  logic                   final_r;
  logic                   last_r;
  logic [BASE_W-1:0]      base_r;
  logic [SAMPLE_BITS-1:0] avg_r;
  logic [TRANS_W-1:0]     trans_r;
  logic                   nob_r;
  logic [MM_W-1:0]        min_r;
  logic [MM_W-1:0]        max_r;

  // result register
  logic                 out_valid_r;
  logic [PIX_OUT_W-1:0] out_pix_r;
  logic [AVG_OUT_W-1:0] out_avg_r;
  logic [TRANS_W-1:0]   out_trans_r;
  logic                 out_nob_r;
  logic [AVG_OUT_W-1:0] out_min_r;
  logic [AVG_OUT_W-1:0] out_max_r;
  logic                 out_last_r;

  logic                   in_accept;
  logic [PIX_W-1:0]       pix_cur;
  logic [NF_W-1:0]        frame_cur;
  logic [CMP_W-1:0]       nf_cfg;
  logic [NF_W-1:0]        nf_eff;
  logic                   final_cur;
  logic [ACC_W-1:0]       acc_rd;
  logic [BASE_W-1:0]      base_rd;
  logic [ACC_W:0]         acc_sum;
  logic [ACC_W-1:0]       acc_nxt;
  logic [SAMPLE_BITS-1:0] avg_nxt;
  logic [PROD_W-1:0]      avg_pct;
  logic [MM_W-1:0]        min_nxt;
  logic [MM_W-1:0]        max_nxt;
  logic                   out_load;
  logic                   base_we;
  logic [PIX_W-1:0]       base_waddr;
  logic [BASE_W-1:0]      base_wdata;
  logic                   div_start;
  logic [DIV_N-1:0]       div_a;
  logic [DIV_M-1:0]       div_b;
  logic [DIV_N-1:0]       div_q;
  div_stat_t              div_stat;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;

  always_comb begin
    nf_cfg = CMP_W'(num_frames_r);
    if (nf_cfg == '0) begin
      nf_eff = NF_W'(1);
    end else if (nf_cfg > CMP_W'(MAX_FRAMES)) begin
      nf_eff = NF_W'(MAX_FRAMES);
    end else begin
      nf_eff = NF_W'(nf_cfg);
    end
    pix_cur   = in_ch.restart ? '0 : pix_r;
    frame_cur = in_ch.restart ? '0 : frame_r;
    final_cur = ((NF_W + 1)'(frame_cur) + (NF_W + 1)'(1)) >= (NF_W + 1)'(nf_eff);
  end

  // accumulate: frame zero overwrites, later frames add with saturation
  always_comb begin
    acc_sum = {1'b0, acc_rd} + (ACC_W + 1)'(sample_r);
    if (first_frame_r) begin
      acc_nxt = ACC_W'(sample_r);
    end else if (acc_sum[ACC_W]) begin
      acc_nxt = '1;
    end else begin
      acc_nxt = acc_sum[ACC_W-1:0];
    end
  end

  always_comb begin
    if (div_q > DIV_N'(SAMPLE_MAX)) begin
      avg_nxt = SAMPLE_MAX;
    end else begin
      avg_nxt = div_q[SAMPLE_BITS-1:0];
    end
    avg_pct = PROD_W'(avg_nxt) * PROD_W'(PERCENT);
    if (pix_item_r == '0) begin
      min_nxt = MM_W'(avg_nxt);
      max_nxt = MM_W'(avg_nxt);
    end else begin
      min_nxt = (MM_W'(avg_nxt) < min_r) ? MM_W'(avg_nxt) : min_r;
      max_nxt = (MM_W'(avg_nxt) > max_r) ? MM_W'(avg_nxt) : max_r;
    end
  end

  // shared divider: average first, then transmission when a baseline exists
  always_comb begin
    div_start = 1'b0;
    div_a     = DIV_N'(acc_nxt);
    div_b     = DIV_M'(nf_eff);
    case (state_r)
      S_ACC: begin
        div_start = final_r;
      end
      S_AVG: begin
        div_start = div_stat.done && (base_r != '0);
        div_a     = DIV_N'(avg_pct);
        div_b     = DIV_M'(base_r);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_comb begin
    base_we    = 1'b0;
    base_waddr = pix_item_r;
    base_wdata = BASE_W'(avg_nxt);
    if (state_r == S_CLEAR) begin
      base_we    = 1'b1;
      base_waddr = clr_r;
      base_wdata = '0;
    end else if (state_r == S_AVG && div_stat.done && capture_r) begin
      base_we = 1'b1;
    end
  end

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  lsfa_ram #(.WIDTH(ACC_W), .DEPTH(PIXELS)) u_acc_ram (
    .clk   (clk),
    .we    (state_r == S_ACC),
    .waddr (pix_item_r),
    .wdata (acc_nxt),
    .re    (in_accept),
    .raddr (pix_cur),
    .rdata (acc_rd)
  );

  lsfa_ram #(.WIDTH(BASE_W), .DEPTH(PIXELS)) u_base_ram (
    .clk   (clk),
    .we    (base_we),
    .waddr (base_waddr),
    .wdata (base_wdata),
    .re    (in_accept),
    .raddr (pix_cur),
    .rdata (base_rd)
  );

  lsfa_div #(.N(DIV_N), .M(DIV_M)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .stat     (div_stat),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      num_frames_r <= NUM_FRAMES_W'(1);
      capture_r    <= 1'b0;
      pix_r        <= '0;
      frame_r      <= '0;
      min_r        <= MM_W'(MIN_RESET);
      max_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NUM_FRAMES: num_frames_r <= cfg_data;
          REG_CAPTURE:    capture_r    <= cfg_data[0];
          default:        ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == PIX_LAST) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            sample_r      <= SAMPLE_BITS'(in_ch.sample);
            pix_item_r    <= pix_cur;
            first_frame_r <= (frame_cur == '0);
            final_r       <= final_cur;
            last_r        <= final_cur && (pix_cur == PIX_LAST);
            if (pix_cur == PIX_LAST) begin
              pix_r   <= '0;
              frame_r <= final_cur ? '0 : frame_cur + 1'b1;
            end else begin
              pix_r   <= pix_cur + 1'b1;
              frame_r <= frame_cur;
            end
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          base_r  <= base_rd;
          state_r <= final_r ? S_AVG : S_IDLE;
        end
        S_AVG: begin
          if (div_stat.done) begin
            avg_r <= avg_nxt;
            min_r <= min_nxt;
            max_r <= max_nxt;
            if (base_r == '0) begin
              trans_r <= '0;
              nob_r   <= 1'b1;
              state_r <= S_OUT;
            end else begin
              state_r <= S_TRN;
            end
          end
        end
        S_TRN: begin
          if (div_stat.done) begin
            trans_r <= TRANS_W'(div_q);
            nob_r   <= 1'b0;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_pix_r   <= PIX_OUT_W'(pix_item_r);
            out_avg_r   <= AVG_OUT_W'(avg_r);
            out_trans_r <= trans_r;
            out_nob_r   <= nob_r;
            out_min_r   <= AVG_OUT_W'(min_r);
            out_max_r   <= AVG_OUT_W'(max_r);
            out_last_r  <= last_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_index  = out_pix_r;
  assign out_ch.average      = out_avg_r;
  assign out_ch.transmission = out_trans_r;
  assign out_ch.no_baseline  = out_nob_r;
  assign out_ch.running_min  = out_min_r;
  assign out_ch.running_max  = out_max_r;
  assign out_ch.last         = out_last_r;

  a_ready_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
                                     in_ch.ready |-> !div_stat.busy)
    else $error("sample taken while divider busy");
  a_beat_from_out: assert property (@(posedge clk) disable iff (!rst_n)
                                    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result beat raised outside output step");
  a_acc_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
                                       state_r == S_ACC |-> $past(in_accept))
    else $error("accumulator update without accepted sample");

endmodule
`default_nettype wire

### sim/lsfa_frame_check.sv
`default_nettype none
module lsfa_frame_check #(
  parameter int PIXELS     = 256,
  parameter int MAX_FRAMES = 256
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [lsfa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lsfa_pkg::CFG_DATA_W-1:0]   cfg_data,
  lsfa_in_if                                     in_ch,
  lsfa_out_if                                    out_ch,
  output int unsigned                            fail_count,
  output int unsigned                            results_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import lsfa_pkg::*;

  localparam int unsigned ACC_MAX    = (1 << ACC_W) - 1;
  localparam int unsigned SAMPLE_MAX = (1 << SAMPLE_W) - 1;

  typedef struct packed {
    logic [PIX_OUT_W-1:0] pixel_index;
    logic [AVG_OUT_W-1:0] average;
    logic [TRANS_W-1:0]   transmission;
    logic                 no_baseline;
    logic [AVG_OUT_W-1:0] running_min;
    logic [AVG_OUT_W-1:0] running_max;
    logic                 last;
  } pixel_result_t;

  logic [ACC_W-1:0]        acc_mem  [PIXELS];
  logic [BASE_W-1:0]       base_mem [PIXELS];
  int unsigned             pix_pos;
  int unsigned             frame_pos;
  logic [AVG_OUT_W-1:0]    lo_avg;
  logic [AVG_OUT_W-1:0]    hi_avg;
  logic [NUM_FRAMES_W-1:0] frames_reg;
  logic                    capture_reg;
  pixel_result_t           pixel_results_q[$];

  task automatic report_mismatch(input string what, input int unsigned got_v,
                                 input int unsigned want_v);
    $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got_v, want_v);
    fail_count++;
  endtask

  // Accumulate one sample and queue the pixel result if this is the final frame.
  task automatic integrate_pixel(input logic [SAMPLE_W-1:0] s, input logic restart);
    int unsigned   nf;
    int unsigned   p;
    int unsigned   sum;
    int unsigned   avg;
    int unsigned   base;
    bit            fin;
    pixel_result_t r;
    nf = (frames_reg == 0) ? 1 : (frames_reg > MAX_FRAMES) ? MAX_FRAMES : frames_reg;
    if (restart) begin
      pix_pos   = 0;
      frame_pos = 0;
    end
    if (pix_pos >= PIXELS) pix_pos = 0;
    p = pix_pos;
    if (frame_pos == 0) begin
      sum = s;
    end else begin
      sum = acc_mem[p] + s;
      if (sum > ACC_MAX) sum = ACC_MAX;
    end
    acc_mem[p] = ACC_W'(sum);
    fin = (frame_pos + 1 >= nf);
    if (p + 1 >= PIXELS) begin
      pix_pos   = 0;
      frame_pos = fin ? 0 : frame_pos + 1;
    end else begin
      pix_pos = p + 1;
    end
    if (fin) begin
      avg = sum / nf;
      if (avg > SAMPLE_MAX) avg = SAMPLE_MAX;
      // min/max start over at pixel 0 of the final frame
      if (p == 0) begin
        lo_avg = AVG_OUT_W'(avg);
        hi_avg = AVG_OUT_W'(avg);
      end else begin
        if (avg < lo_avg) lo_avg = AVG_OUT_W'(avg);
        if (avg > hi_avg) hi_avg = AVG_OUT_W'(avg);
      end
      base            = base_mem[p];
      r.pixel_index   = PIX_OUT_W'(p);
      r.average       = AVG_OUT_W'(avg);
      r.transmission  = TRANS_W'((base == 0) ? 0 : (avg * PERCENT) / base);
      r.no_baseline   = (base == 0);
      r.running_min   = lo_avg;
      r.running_max   = hi_avg;
      r.last          = (p == PIXELS - 1);
      // baseline is replaced only after this pixel's transmission is formed
      if (capture_reg) base_mem[p] = BASE_W'(avg);
      pixel_results_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin : track
    pixel_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < PIXELS; i++) begin
        acc_mem[i]  = '0;
        base_mem[i] = '0;
      end
      pix_pos      = 0;
      frame_pos    = 0;
      lo_avg       = AVG_OUT_W'(MIN_RESET);
      hi_avg       = '0;
      frames_reg   = 1;
      capture_reg  = 1'b0;
      fail_count   = 0;
      pixel_results_q.delete();
      results_owed <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_NUM_FRAMES) frames_reg = cfg_data[NUM_FRAMES_W-1:0];
        else if (cfg_index == REG_CAPTURE) capture_reg = cfg_data[0];
      end
      if (in_ch.valid && in_ch.ready) integrate_pixel(in_ch.sample, in_ch.restart);
      if (out_ch.valid && out_ch.ready) begin
        if (pixel_results_q.size() == 0) begin
          report_mismatch("unexpected result beat, pixel_index", out_ch.pixel_index, 0);
        end else begin
          want = pixel_results_q.pop_front();
          if (out_ch.pixel_index !== want.pixel_index)
            report_mismatch("pixel_index", out_ch.pixel_index, want.pixel_index);
          if (out_ch.average !== want.average)
            report_mismatch("average", out_ch.average, want.average);
          if (out_ch.transmission !== want.transmission)
            report_mismatch("transmission", out_ch.transmission, want.transmission);
          if (out_ch.no_baseline !== want.no_baseline)
            report_mismatch("no_baseline", out_ch.no_baseline, want.no_baseline);
          if (out_ch.running_min !== want.running_min)
            report_mismatch("running_min", out_ch.running_min, want.running_min);
          if (out_ch.running_max !== want.running_max)
            report_mismatch("running_max", out_ch.running_max, want.running_max);
          if (out_ch.last !== want.last)
            report_mismatch("last", out_ch.last, want.last);
        end
      end
      results_owed <= pixel_results_q.size();
    end
  end

endmodule
`default_nettype wire

### sim/tb.sv
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lsfa_pkg::*;

  localparam int PIXELS         = 256;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int QUIET_CYCLES   = 100;
  localparam int LIMIT_NS       = 1_000_000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int unsigned fail_count;
  int unsigned results_owed;
  int unsigned tx_idle_max = 8;
  int unsigned rx_idle_max = 8;
  logic        rx_hold_req = 1'b0;
  logic        rx_hold_taken = 1'b0;

  lsfa_in_if  in_ch ();
  lsfa_out_if out_ch ();

  always #1 clk = ~clk;

  linear_sensor_frame_averager #(.PIXELS(PIXELS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  lsfa_frame_check #(.PIXELS(PIXELS)) frame_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  task automatic send_pixel(input logic [SAMPLE_W-1:0] s, input logic r);
    int unsigned gap;
    gap = $urandom_range(0, tx_idle_max);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.sample  <= s;
    in_ch.restart <= r;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic feed_pixels(input int count, input bit restart_first, input bit noisy);
    logic [SAMPLE_W-1:0] s;
    logic                r;
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) begin
        tx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
        rx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      end
      case ($urandom_range(0, 9))
        0:       s = '0;
        1:       s = '1;
        2:       s = 1;
        3:       s = SAMPLE_W'($urandom_range(0, 15));
        default: s = SAMPLE_W'($urandom_range(0, (1 << SAMPLE_W) - 1));
      endcase
      r = (i == 0 && restart_first) || (noisy && $urandom_range(0, 99) == 0);
      send_pixel(s, r);
    end
  endtask

  // Drain every outstanding result, then give the block time to finish a
  // sample that produces no beat.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : result_pacer
    int unsigned gap;
    out_ch.ready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_req && !rx_hold_taken) begin
        rx_hold_taken = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end
      gap = $urandom_range(0, rx_idle_max);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.sample  = '0;
    in_ch.restart = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // corners at reset config: one frame, empty baseline
    send_pixel(12'h000, 1'b0);
    send_pixel(12'hFFF, 1'b0);
    send_pixel(12'h001, 1'b0);
    send_pixel(12'hFFE, 1'b0);
    send_pixel(12'hAAA, 1'b0);
    send_pixel(12'h555, 1'b0);
    send_pixel(12'h800, 1'b1);
    send_pixel(12'h7FF, 1'b0);
    send_pixel(12'h000, 1'b0);
    send_pixel(12'hFFF, 1'b0);
    wait_idle();

    // smallest and largest baseline, then the transmission extremes against them
    write_reg(REG_CAPTURE, 1);
    send_pixel(12'h001, 1'b1);
    send_pixel(12'hFFF, 1'b0);
    send_pixel(12'h000, 1'b0);
    wait_idle();
    write_reg(REG_CAPTURE, 0);
    send_pixel(12'hFFF, 1'b1);
    send_pixel(12'hFFF, 1'b0);
    send_pixel(12'h000, 1'b0);
    wait_idle();

    // zero frame count acts as one; capture a full baseline
    write_reg(REG_NUM_FRAMES, 0);
    write_reg(REG_CAPTURE, 1);
    feed_pixels(PIXELS, 1'b1, 1'b0);
    wait_idle();

    write_reg(REG_CAPTURE, 0);
    write_reg(REG_NUM_FRAMES, 1);
    feed_pixels(100, 1'b1, 1'b1);
    rx_hold_req <= 1'b1;
    feed_pixels(80, 1'b0, 1'b1);
    wait_idle();
    feed_pixels(76, 1'b0, 1'b1);
    wait_idle();

    // large frame counts: accumulate only, no beats
    write_reg(REG_NUM_FRAMES, 256);
    feed_pixels(40, 1'b1, 1'b0);
    wait_idle();
    write_reg(REG_NUM_FRAMES, 511);
    feed_pixels(20, 1'b0, 1'b0);
    wait_idle();
    // dropping to one makes the rest of frame 0 final
    write_reg(REG_NUM_FRAMES, 1);
    feed_pixels(30, 1'b0, 1'b0);
    wait_idle();

    // four frames, lowered to two partway through the second frame
    write_reg(REG_NUM_FRAMES, 4);
    write_reg(REG_CAPTURE, CFG_DATA_W'($urandom_range(0, 1)));
    feed_pixels(PIXELS + 20, 1'b1, 1'b0);
    wait_idle();
    write_reg(REG_NUM_FRAMES, 2);
    feed_pixels(PIXELS - 20, 1'b0, 1'b0);
    wait_idle();

    write_reg(REG_CAPTURE, 0);
    write_reg(REG_NUM_FRAMES, 1);
    feed_pixels(50, 1'b1, 1'b1);
    wait_idle();

    if (fail_count == 0 && results_owed == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

### sim.f
src/lsfa_pkg.sv
src/lsfa_in_if.sv
src/lsfa_out_if.sv
src/lsfa_ram.sv
src/lsfa_div.sv
src/linear_sensor_frame_averager.sv
sim/lsfa_frame_check.sv
sim/tb.sv
